// ===== rtl/lps_pkg.sv =====
package lps_pkg;
  localparam int MaxDegree = 31;
  localparam int DegW = 5;
  localparam int ValW = 18;
  localparam int OneQ = 65536;

  // B(l) = round(l/(l+1)) in Q2.16, ties up, as a constant table.
  function automatic logic [17:0] coef_b(input logic [DegW-1:0] l);
    logic [17:0] b;
    case (l)
      5'd1:    b = 18'd32768;
      5'd2:    b = 18'd43691;
      5'd3:    b = 18'd49152;
      5'd4:    b = 18'd52429;
      5'd5:    b = 18'd54613;
      5'd6:    b = 18'd56174;
      5'd7:    b = 18'd57344;
      5'd8:    b = 18'd58254;
      5'd9:    b = 18'd58982;
      5'd10:   b = 18'd59578;
      5'd11:   b = 18'd60075;
      5'd12:   b = 18'd60495;
      5'd13:   b = 18'd60855;
      5'd14:   b = 18'd61167;
      5'd15:   b = 18'd61440;
      5'd16:   b = 18'd61681;
      5'd17:   b = 18'd61895;
      5'd18:   b = 18'd62087;
      5'd19:   b = 18'd62259;
      5'd20:   b = 18'd62415;
      5'd21:   b = 18'd62557;
      5'd22:   b = 18'd62687;
      5'd23:   b = 18'd62805;
      5'd24:   b = 18'd62915;
      5'd25:   b = 18'd63015;
      5'd26:   b = 18'd63109;
      5'd27:   b = 18'd63195;
      5'd28:   b = 18'd63276;
      5'd29:   b = 18'd63351;
      5'd30:   b = 18'd63422;
      5'd31:   b = 18'd63488;
      default: b = 18'd0;
    endcase
    return b;
  endfunction

  // A(l) = (2l+1)/(l+1) = 1 + l/(l+1), so it is B(l) plus one in Q2.16.
  function automatic logic [17:0] coef_a(input logic [DegW-1:0] l);
    return coef_b(l) + 18'(OneQ);
  endfunction

  typedef struct packed {
    logic [DegW-1:0] degree;
    logic signed [ValW-1:0] poly_value;
    logic last;
  } result_t;

  // Token handed from cell to cell along the chain.
  typedef struct packed {
    logic valid;
    logic [DegW-1:0] n;
    logic signed [ValW-1:0] x;
    logic signed [ValW-1:0] p;
    logic signed [ValW-1:0] pm1;
  } token_t;
endpackage

// ===== rtl/lps_if.sv =====
interface lps_in_if;
  logic valid;
  logic ready;
  logic signed [17:0] x_value;
  modport source (output valid, output x_value, input ready);
  modport sink (input valid, input x_value, output ready);
endinterface

interface lps_out_if;
  logic valid;
  logic ready;
  logic [4:0] degree;
  logic signed [17:0] poly_value;
  logic last;
  modport source (output valid, output degree, output poly_value, output last, input ready);
  modport sink (input valid, input degree, input poly_value, input last, output ready);
endinterface

// ===== rtl/lps_cell.sv =====
module lps_cell (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic [lps_pkg::DegW-1:0] l,
  input  lps_pkg::token_t tin,
  output lps_pkg::token_t tout,
  output logic signed [lps_pkg::ValW-1:0] pnew
);
  import lps_pkg::*;
  logic signed [35:0] xa;
  logic signed [36:0] bp;
  logic signed [35:0] xa_r;
  logic signed [36:0] bp_r;
  token_t t_r;
  logic signed [53:0] m;
  logic signed [54:0] s;
  logic signed [22:0] q;
  logic signed [ValW-1:0] sat;

  // A(l)*x and B(l)*P(l-1) are formed on the way in and registered, so only
  // the product with P(l) is left after the register of this cell.
  always_comb begin
    xa = 36'(tin.x) * $signed({1'b0, coef_a(l)});
    bp = 37'(tin.pm1) * $signed({1'b0, coef_b(l)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_r.valid <= 1'b0;
    end else if (adv) begin
      t_r <= tin;
      xa_r <= xa;
      bp_r <= bp;
    end
  end

  always_comb begin
    m = 54'(xa_r) * 54'(t_r.p);
    s = 55'(m) - (55'(bp_r) <<< 16) + 55'sd2147483648;
    q = 23'(s >>> 32);
    if (q > 23'sd131071) sat = 18'sd131071;
    else if (q < -23'sd131072) sat = 18'sh20000;
    else sat = q[ValW-1:0];
    tout = t_r;
    tout.pm1 = t_r.p;
    tout.p = sat;
    pnew = sat;
  end
endmodule

// ===== rtl/legendre_polynomial_sequence_top.sv =====
// Legendre polynomial generator, P0..Pn by Bonnet's recurrence.
// in_ch carries one request: the argument x_value (Q2.16), clamped to [-1,1].
// out_ch gives n+1 results per argument: degree, poly_value, last, in
// increasing degree, with last set on degree n.
// cfg_we/cfg_data write max_degree (reset 31). The user writes it only while
// idle; nothing in the block enforces this. One argument is worked at a time:
// a head stage gives degrees 0 and 1, then the argument steps through a chain
// of cells, one cell per degree from 2 up, one cell per cycle while out_ch is
// not stalled. Degree 0 passes through the head register t0 and then the output
// register to out_ch, and each further degree follows the one before in the
// next cycle while the receiver does not stall. A new request is accepted in
// the cycle after the last result has been taken. When out_ch.valid is high
// and out_ch.ready is low, the head stage, the chain and the output register
// all hold. Reset (rst, synchronous) clears the chain and output and sets
// max_degree 31.
module legendre_polynomial_sequence_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [4:0] cfg_data,
  lps_in_if.sink in_ch,
  lps_out_if.source out_ch
);
  import lps_pkg::*;
  localparam int NumCells = MaxDegree - 1;

  logic [DegW-1:0] max_degree;
  logic busy;
  logic adv;
  logic signed [ValW-1:0] xc;
  token_t head;
  token_t t0;
  logic ph;
  token_t cin [1:NumCells];
  token_t tk [1:NumCells];
  logic signed [ValW-1:0] pv [1:NumCells];
  result_t res;
  logic emit;

  always_ff @(posedge clk) begin
    if (rst) max_degree <= 5'(MaxDegree);
    else if (cfg_we) max_degree <= cfg_data;
  end

  assign in_ch.ready = !busy;
  assign adv = !out_ch.valid || out_ch.ready;

  always_comb begin
    if (in_ch.x_value > 18'sd65536) xc = 18'sd65536;
    else if (in_ch.x_value < -18'sd65536) xc = -18'sd65536;
    else xc = in_ch.x_value;
    head.valid = in_ch.valid && !busy;
    head.n = (int'(max_degree) > MaxDegree) ? DegW'(MaxDegree) : max_degree;
    head.x = xc;
    head.p = xc;
    head.pm1 = 18'(OneQ);
  end

  // The head stage emits degrees 0 and 1; cell l produces degree l+1.
  always_ff @(posedge clk) begin
    if (rst) begin
      t0.valid <= 1'b0;
      busy <= 1'b0;
      ph <= 1'b0;
    end else begin
      if (head.valid) begin
        t0 <= head;
        busy <= 1'b1;
        ph <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready && out_ch.last) busy <= 1'b0;
        if (t0.valid && adv) begin
          if (ph || t0.n == '0) t0.valid <= 1'b0;
          ph <= 1'b1;
        end
      end
    end
  end

  // A token moves on only while a higher degree is still wanted.
  always_comb begin
    cin[1] = '0;
    if (t0.valid && ph && t0.n > DegW'(1)) cin[1] = t0;
    for (int i = 2; i <= NumCells; i++) begin
      cin[i] = '0;
      if (tk[i-1].valid && tk[i-1].n > DegW'(i)) cin[i] = tk[i-1];
    end
  end

  genvar g;
  generate
    for (g = 1; g <= NumCells; g++) begin : g_cell
      lps_cell u_cell (.clk(clk), .rst(rst), .adv(adv), .l(DegW'(g)),
                       .tin(cin[g]), .tout(tk[g]), .pnew(pv[g]));
    end
  endgenerate

  // Only one token lives in the chain; find the cell holding it.
  always_comb begin
    emit = 1'b0;
    res = '0;
    if (t0.valid) begin
      emit = 1'b1;
      res.degree = DegW'(ph);
      res.poly_value = ph ? t0.x : 18'(OneQ);
      res.last = (DegW'(ph) == t0.n);
    end
    for (int i = 1; i <= NumCells; i++) begin
      if (tk[i].valid) begin
        emit = 1'b1;
        res.degree = DegW'(i + 1);
        res.poly_value = pv[i];
        res.last = (DegW'(i + 1) == tk[i].n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (adv) begin
      out_ch.valid <= emit;
      out_ch.degree <= res.degree;
      out_ch.poly_value <= res.poly_value;
      out_ch.last <= res.last;
    end
  end
endmodule

// ===== rtl/lps_checker.sv =====
module lps_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [4:0] out_degree
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_degree)) else $error("hold");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("busy");
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_degree == 5'd0 && !out_last |-> !in_ready) else $error("first");
endmodule

bind legendre_polynomial_sequence_top lps_checker u_chk (.clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_last(out_ch.last), .out_degree(out_ch.degree));

// ===== tb/legendre_polynomial_sequence_top_tb.sv =====
module legendre_polynomial_sequence_top_tb;
  import lps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [4:0] cfg_data;

  lps_in_if in_ch ();
  lps_out_if out_ch ();

  legendre_polynomial_sequence_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  logic signed [ValW-1:0] arg_queue[$];
  result_t poly_expected[$];
  logic [4:0] degree_setting;
  int err_count;
  int idle_cycles;
  int in_gap;
  int out_gap;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(5, 40));
  endfunction

  // Rounds a Q.48 sum to Q2.16 (ties toward +inf) and saturates.
  function automatic logic signed [ValW-1:0] round_to_q16(input logic signed [63:0] s);
    logic signed [63:0] q;
    q = (s + 64'sd2147483648) >>> 32;
    if (q > 64'sd131071) q = 64'sd131071;
    if (q < -64'sd131072) q = -64'sd131072;
    return q[ValW-1:0];
  endfunction

  task automatic predict_legendre(input logic signed [ValW-1:0] x_in);
    logic signed [63:0] x;
    logic signed [63:0] pm1;
    logic signed [63:0] p;
    logic signed [63:0] ca;
    logic signed [63:0] cb;
    logic signed [ValW-1:0] pn;
    int n;
    result_t r;
    n = (degree_setting > MaxDegree) ? MaxDegree : degree_setting;
    x = x_in;
    if (x > OneQ) x = OneQ;
    if (x < -OneQ) x = -OneQ;
    r.degree = DegW'(0);
    r.poly_value = 18'(OneQ);
    r.last = (n == 0);
    poly_expected.push_back(r);
    if (n == 0) return;
    r.degree = DegW'(1);
    r.poly_value = x[ValW-1:0];
    r.last = (n == 1);
    poly_expected.push_back(r);
    pm1 = OneQ;
    p = x;
    for (int l = 1; l < n; l++) begin
      ca = ((2 * l + 1) * 2 * OneQ + (l + 1)) / (2 * (l + 1));
      cb = (l * 2 * OneQ + (l + 1)) / (2 * (l + 1));
      pn = round_to_q16(ca * x * p - cb * pm1 * OneQ);
      pm1 = p;
      p = pn;
      r.degree = DegW'(l + 1);
      r.poly_value = pn;
      r.last = ((l + 1) == n);
      poly_expected.push_back(r);
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Driver: presents queued arguments with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else begin
      if (in_ch.valid) predict_legendre(in_ch.x_value);
      if (in_gap > 0 || arg_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.x_value <= arg_queue.pop_front();
        in_gap <= rand_gap();
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (poly_expected.size() == 0) begin
          report("unexpected result, degree", out_ch.degree, -1);
        end else begin
          want = poly_expected.pop_front();
          if (out_ch.degree !== want.degree) report("degree", out_ch.degree, want.degree);
          if (out_ch.poly_value !== want.poly_value)
            report("poly_value", out_ch.poly_value, want.poly_value);
          if (out_ch.last !== want.last) report("last", out_ch.last, want.last);
        end
      end
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= WatchdogLimit) begin
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    while (arg_queue.size() != 0 || in_ch.valid || poly_expected.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_degree(input logic [4:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    degree_setting = value;
    @(posedge clk);
  endtask

  function automatic logic signed [ValW-1:0] rand_arg();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 18'($urandom_range(0, 131072) - 65536);
    return 18'($urandom_range(0, 262143));
  endfunction

  initial begin
    logic [4:0] settings[6];
    err_count = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.x_value = '0;
    out_ch.ready = 1'b0;
    degree_setting = 5'd31;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: reset degree, extremes and clamping of the argument.
    arg_queue.push_back(18'sh00000);
    arg_queue.push_back(18'sd65536);
    arg_queue.push_back(-18'sd65536);
    arg_queue.push_back(18'sd131071);
    arg_queue.push_back(18'sh20000);
    arg_queue.push_back(18'sd65537);
    arg_queue.push_back(18'sd32768);
    arg_queue.push_back(18'sh15555);
    drain();
    write_degree(5'd0);
    arg_queue.push_back(18'sd131071);
    arg_queue.push_back(-18'sd1);
    drain();
    write_degree(5'd1);
    arg_queue.push_back(18'sh20000);
    arg_queue.push_back(18'sd12345);
    drain();
    settings = '{5'd31, 5'd2, 5'd7, 5'd0, 5'd16, 5'd31};
    foreach (settings[i]) begin
      write_degree(settings[i]);
      repeat (70) arg_queue.push_back(rand_arg());
      drain();
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
